// File: rtl/core/cns_pkg.sv
// Shared constants, register index codes and helpers for the chord note selector.
// No dependencies; compiled first.
package cns_pkg;

   localparam int NOTE_RANGE_DEF = 128;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int IDX_W      = 8;   // note index / quotient width
   localparam int SPAN_W     = 4;   // octave span, at most 11
   localparam int PC_W       = 4;   // set bits in one 8-bit group
   localparam int LAST_W     = 9;   // signed top note before range check
   localparam int OS_W       = 12;  // octave count times span

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL,
      CSR_BASE_VEL,
      CSR_VEL_GAIN,
      CSR_BASE_DUR,
      CSR_DUR_SHIFT,
      CSR_CHORD_XPOSE,
      CSR_OUT_XPOSE,
      CSR_SUPPRESS
   } csr_index_type;

   localparam logic [14:0] BASE_VEL_RST = 15'd12800;
   localparam logic [15:0] BASE_DUR_RST = 16'd100;

   typedef struct packed {
      logic en_a;
      logic en_b;
   } div_ctl_type;

   // x / 12 for x below 256, by reciprocal multiply
   function automatic logic [4:0] div12(input logic [7:0] x);
      logic [15:0] p;
      p = 16'(x) * 16'd171;
      return p[15:11];
   endfunction

endpackage

// File: rtl/core/cns_ifs.sv
// Valid/ready channel interfaces for the chord note selector: trigger beats in,
// note beats out. No dependencies.
interface cns_req_if;
   logic               valid;
   logic               ready;
   logic               gate_open;
   logic               trigger;
   logic [7:0]         note_index;
   logic signed [15:0] velocity_mod;
   logic [15:0]        duration_scale;
   logic [63:0]        chord_low;
   logic [63:0]        chord_high;

   modport source (output valid, gate_open, trigger, note_index, velocity_mod,
                   duration_scale, chord_low, chord_high, input ready);
   modport sink   (input valid, gate_open, trigger, note_index, velocity_mod,
                   duration_scale, chord_low, chord_high, output ready);
endinterface

interface cns_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         note_channel;
   logic signed [8:0]  note_number;
   logic [14:0]        velocity;
   logic [23:0]        duration_ms;
   logic               no_retrigger;

   modport source (output valid, note_channel, note_number, velocity, duration_ms,
                   no_retrigger, input ready);
   modport sink   (input valid, note_channel, note_number, velocity, duration_ms,
                   no_retrigger, output ready);
endinterface

// File: rtl/core/cns_divider.sv
// Two-stage restoring divider: note index by kept-note count, four quotient bits
// per stage. Depends on cns_pkg.
module cns_divider import cns_pkg::*; #(
   parameter int CNT_W = 8
) (
   input  logic              clock,
   input  div_ctl_type       ctl,
   input  logic [IDX_W-1:0]  dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic [IDX_W-1:0]  quotient,
   output logic [CNT_W-1:0]  remainder
);

   localparam int HALF = IDX_W / 2;

   logic [CNT_W-1:0] p_rem_ff, p_rem_in;
   logic [IDX_W-1:0] p_q_ff, p_q_in;
   logic [IDX_W-1:0] p_num_ff;
   logic [CNT_W-1:0] p_div_ff;
   logic [IDX_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0] rem_ff, rem_in;

   // upper quotient bits
   always_comb begin
      logic [CNT_W:0] rx;
      p_rem_in = '0;
      p_q_in   = '0;
      for (int s = IDX_W - 1; s >= HALF; s--) begin
         rx = {p_rem_in, dividend[s]};
         if (rx >= {1'b0, divisor}) begin
            rx        = rx - {1'b0, divisor};
            p_q_in[s] = 1'b1;
         end
         p_rem_in = rx[CNT_W-1:0];
      end
   end

   // lower quotient bits
   always_comb begin
      logic [CNT_W:0] rx;
      rem_in  = p_rem_ff;
      quot_in = p_q_ff;
      for (int s = HALF - 1; s >= 0; s--) begin
         rx = {rem_in, p_num_ff[s]};
         if (rx >= {1'b0, p_div_ff}) begin
            rx         = rx - {1'b0, p_div_ff};
            quot_in[s] = 1'b1;
         end
         rem_in = rx[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_a) begin
         p_rem_ff <= p_rem_in;
         p_q_ff   <= p_q_in;
         p_num_ff <= dividend;
         p_div_ff <= divisor;
      end
      if (ctl.en_b) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/chord_note_selector_top.sv
// Chord note selector top level: eight-stage pipeline from trigger beat to note beat.
// Depends on cns_pkg, cns_ifs (cns_req_if, cns_rsp_if) and cns_divider.
//
// req_ch carries one trigger beat per cycle: gate, trigger, note index, velocity and
// duration modulation and the 128-bit chord mask. A beat with gate_open and trigger
// both high, whose chord keeps at least one note after chord transpose and range
// check, yields one note beat on rsp_ch; any other beat is taken and dropped.
// csr_we/csr_index/csr_wdata write the eight settings registers; write them only
// while no beat is in flight.
// Throughput: one beat per cycle while rsp_ch.ready is high; the stages are kept-note
// mask, popcount, prefix sum, two halves of the index divider, group pick, bit pick and
// octave fold, each one register deep.
// When rsp_ch.ready is low the output stage holds its beat; bubbles further up still
// close, and req_ch.ready drops only once every stage holds a beat.
// Synchronous reset empties the pipeline and restores the register defaults: channel
// 0, base velocity 12800, gain 0, base duration 100 ms, shift 0, no transposes and
// retrigger suppression on.
module chord_note_selector_top import cns_pkg::*; #(
   parameter int NOTE_RANGE = NOTE_RANGE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cns_req_if.sink               req_ch,
   cns_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NGRP  = (NOTE_RANGE + 7) / 8;
   localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int NB    = GW + 3;
   localparam int KW    = NGRP * 8;
   localparam int CNT_W = $clog2(NOTE_RANGE + 1);
   localparam int NLVL  = $clog2(NGRP);
   localparam int THR   = NOTE_RANGE - 12;

   localparam int NSTG = 8;
   localparam int ST_A = 0;
   localparam int ST_B = 1;
   localparam int ST_C = 2;
   localparam int ST_D = 3;
   localparam int ST_E = 4;
   localparam int ST_F = 5;
   localparam int ST_G = 6;
   localparam int ST_H = 7;

   typedef struct packed {
      logic [14:0] velocity;
      logic [23:0] duration_ms;
   } side_type;

   // ---------------- settings registers ----------------
   logic [3:0]         channel_ff;
   logic [14:0]        base_vel_ff;
   logic signed [15:0] vel_gain_ff;
   logic [15:0]        base_dur_ff;
   logic [2:0]         dur_shift_ff;
   logic [5:0]         chord_xpose_ff;
   logic [5:0]         out_xpose_ff;
   logic               suppress_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff     <= '0;
         base_vel_ff    <= BASE_VEL_RST;
         vel_gain_ff    <= '0;
         base_dur_ff    <= BASE_DUR_RST;
         dur_shift_ff   <= '0;
         chord_xpose_ff <= '0;
         out_xpose_ff   <= '0;
         suppress_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL:     channel_ff     <= csr_wdata[3:0];
            CSR_BASE_VEL:    base_vel_ff    <= csr_wdata[14:0];
            CSR_VEL_GAIN:    vel_gain_ff    <= csr_wdata;
            CSR_BASE_DUR:    base_dur_ff    <= csr_wdata;
            CSR_DUR_SHIFT:   dur_shift_ff   <= csr_wdata[2:0];
            CSR_CHORD_XPOSE: chord_xpose_ff <= csr_wdata[5:0];
            CSR_OUT_XPOSE:   out_xpose_ff   <= csr_wdata[5:0];
            CSR_SUPPRESS:    suppress_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic [NSTG-1:0] v_ff, v_in, en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_ch.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ch.ready = en[ST_A];

   // ---------------- stage registers ----------------
   logic [NOTE_RANGE-1:0] a_k_ff, a_k_in;
   logic [LAST_W-1:0]     a_last_ff, a_last_in;
   logic [IDX_W-1:0]      a_idx_ff;
   logic signed [31:0]    a_vp_ff, a_vp_in;
   logic [31:0]           a_dp_ff, a_dp_in;

   logic [NOTE_RANGE-1:0] b_k_ff;
   logic [PC_W-1:0]       b_pc_ff [NGRP];
   logic [PC_W-1:0]       b_pc_in [NGRP];
   logic [NB-1:0]         b_first_ff, b_first_in;
   logic [LAST_W-1:0]     b_last_ff;
   logic [IDX_W-1:0]      b_idx_ff;
   side_type              b_side_ff, b_side_in;

   logic [NOTE_RANGE-1:0] c_k_ff;
   logic [CNT_W-1:0]      c_excl_ff [NGRP];
   logic [CNT_W-1:0]      c_excl_in [NGRP];
   logic [CNT_W-1:0]      c_count_ff, c_count_in;
   logic [SPAN_W-1:0]     c_span_ff, c_span_in;
   logic [IDX_W-1:0]      c_idx_ff;
   side_type              c_side_ff;

   logic [NOTE_RANGE-1:0] d_k_ff;
   logic [CNT_W-1:0]      d_excl_ff [NGRP];
   logic [SPAN_W-1:0]     d_span_ff;
   side_type              d_side_ff;

   logic [NOTE_RANGE-1:0] e_k_ff;
   logic [CNT_W-1:0]      e_excl_ff [NGRP];
   logic [SPAN_W-1:0]     e_span_ff;
   side_type              e_side_ff;

   logic [7:0]            f_byte_ff, f_byte_in;
   logic [2:0]            f_rank_ff, f_rank_in;
   logic [GW-1:0]         f_g_ff, f_g_in;
   logic [OS_W-1:0]       f_os_ff, f_os_in;
   side_type              f_side_ff;

   logic [NB-1:0]         g_base_ff, g_base_in;
   logic                  g_fold_ff, g_fold_in;
   side_type              g_side_ff;

   logic [8:0]            h_note_ff, h_note_in;
   side_type              h_side_ff;

   // ---------------- stage A: kept-note mask, top note, products ----------------
   always_comb begin
      logic [127:0]          full;
      logic [NOTE_RANGE-1:0] m;
      logic [5:0]            neg_sh;
      logic [NB-1:0]         hi_idx;
      full   = {req_ch.chord_high, req_ch.chord_low};
      m      = full[NOTE_RANGE-1:0];
      neg_sh = 6'd0 - chord_xpose_ff;
      a_k_in = chord_xpose_ff[5] ? (m >> neg_sh) : (m << chord_xpose_ff);
      hi_idx = '0;
      for (int i = 0; i < NOTE_RANGE; i++) begin
         if (m[i]) hi_idx = NB'(i);
      end
      a_last_in = LAST_W'(hi_idx)
                + {{(LAST_W-6){chord_xpose_ff[5]}}, chord_xpose_ff};
      a_vp_in   = vel_gain_ff * req_ch.velocity_mod;
      a_dp_in   = base_dur_ff * req_ch.duration_scale;
   end

   // ---------------- stage B: group counts, lowest note, velocity, duration ----------
   always_comb begin
      logic [KW-1:0]      kpad;
      logic signed [31:0] vp_rnd;
      logic signed [17:0] vp_sh;
      logic signed [18:0] vel_sum;
      logic [39:0]        d_sh;
      logic [39:0]        d_rnd;
      kpad = KW'(a_k_ff);
      for (int g = 0; g < NGRP; g++) begin
         b_pc_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            b_pc_in[g] = b_pc_in[g] + PC_W'(kpad[8*g+b]);
         end
      end
      b_first_in = '0;
      for (int i = NOTE_RANGE - 1; i >= 0; i--) begin
         if (a_k_ff[i]) b_first_in = NB'(i);
      end

      vp_rnd  = a_vp_ff + 32'sd8192;
      vp_sh   = vp_rnd[31:14];
      vel_sum = $signed({4'b0000, base_vel_ff}) + 19'(vp_sh);
      if (vel_sum < 0) begin
         b_side_in.velocity = '0;
      end else if (vel_sum > 19'sd32767) begin
         b_side_in.velocity = '1;
      end else begin
         b_side_in.velocity = vel_sum[14:0];
      end

      d_sh  = 40'(a_dp_ff) << dur_shift_ff;
      d_rnd = d_sh + 40'd2048;
      b_side_in.duration_ms = (|d_rnd[39:36]) ? '1 : d_rnd[35:12];
   end

   // ---------------- stage C: prefix counts and octave span ----------------
   always_comb begin
      logic [CNT_W-1:0]  incl [NGRP];
      logic [LAST_W-1:0] diff;
      for (int g = 0; g < NGRP; g++) begin
         incl[g] = CNT_W'(b_pc_ff[g]);
      end
      for (int lvl = 0; lvl < NLVL; lvl++) begin
         for (int g = NGRP - 1; g >= 0; g--) begin
            if (g >= (1 << lvl)) incl[g] = incl[g] + incl[g - (1 << lvl)];
         end
      end
      for (int g = 0; g < NGRP; g++) begin
         c_excl_in[g] = incl[g] - CNT_W'(b_pc_ff[g]);
      end
      c_count_in = incl[NGRP-1];
      diff       = b_last_ff - LAST_W'(b_first_ff);
      c_span_in  = SPAN_W'(div12(diff[7:0])) + SPAN_W'(1);
   end

   // ---------------- stages D and E: index divided by count ----------------
   div_ctl_type      div_ctl;
   logic [IDX_W-1:0] div_q;
   logic [CNT_W-1:0] div_r;

   assign div_ctl.en_a = en[ST_D];
   assign div_ctl.en_b = en[ST_E];

   cns_divider #(
      .CNT_W (CNT_W)
   ) u_divider (
      .clock     (clock),
      .ctl       (div_ctl),
      .dividend  (c_idx_ff),
      .divisor   (c_count_ff),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // ---------------- stage F: pick the group holding the chosen note ----------------
   always_comb begin
      logic [KW-1:0]    kpad;
      logic [CNT_W-1:0] rank_full;
      kpad   = KW'(e_k_ff);
      f_g_in = '0;
      for (int j = 1; j < NGRP; j++) begin
         if (e_excl_ff[j] <= div_r) f_g_in = f_g_in + GW'(1);
      end
      rank_full = div_r - e_excl_ff[f_g_in];
      f_rank_in = rank_full[2:0];
      f_byte_in = kpad[8*f_g_in +: 8];
      f_os_in   = OS_W'(div_q) * OS_W'(e_span_ff);
   end

   // ---------------- stage G: bit within group, octave jump, fold test ----------------
   always_comb begin
      logic [3:0]    cnt;
      logic [2:0]    pos;
      logic          found;
      logic [NB-1:0] base;
      logic [15:0]   tot;
      cnt   = '0;
      pos   = '0;
      found = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (f_byte_ff[b] && !found && (cnt == {1'b0, f_rank_ff})) begin
            pos   = 3'(b);
            found = 1'b1;
         end
         cnt = cnt + 4'(f_byte_ff[b]);
      end
      base      = {f_g_ff, pos};
      tot       = 16'({f_os_ff, 3'b000}) + 16'({f_os_ff, 2'b00}) + 16'(base);
      g_fold_in = tot > 16'(THR);
      // an unfolded note keeps its octave jump; a folded one needs the base only
      g_base_in = g_fold_in ? base : tot[NB-1:0];
   end

   // ---------------- stage H: fold into top octave, output transpose ----------------
   // octave jumps are whole twelves, so the folded note depends on the base note only
   always_comb begin
      logic [7:0]    x;
      logic [4:0]    q12;
      logic [7:0]    m12;
      logic [7:0]    r12;
      logic [NB-1:0] nf;
      x   = 8'(THR + 132) - 8'(g_base_ff);
      q12 = div12(x);
      m12 = {q12, 3'b000} + 8'({q12, 2'b00});
      r12 = x - m12;
      nf  = g_fold_ff ? (NB'(THR) - NB'(r12[3:0])) : g_base_ff;
      h_note_in = 9'(nf) + {{3{out_xpose_ff[5]}}, out_xpose_ff};
   end

   // ---------------- valid bits ----------------
   always_comb begin
      v_in[ST_A] = req_ch.valid && req_ch.gate_open && req_ch.trigger;
      v_in[ST_B] = v_ff[ST_A] && (|a_k_ff);   // empty chord gives no note
      for (int k = ST_C; k < NSTG; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (en[ST_A]) begin
         a_k_ff    <= a_k_in;
         a_last_ff <= a_last_in;
         a_idx_ff  <= req_ch.note_index;
         a_vp_ff   <= a_vp_in;
         a_dp_ff   <= a_dp_in;
      end
      if (en[ST_B]) begin
         b_k_ff     <= a_k_ff;
         b_pc_ff    <= b_pc_in;
         b_first_ff <= b_first_in;
         b_last_ff  <= a_last_ff;
         b_idx_ff   <= a_idx_ff;
         b_side_ff  <= b_side_in;
      end
      if (en[ST_C]) begin
         c_k_ff     <= b_k_ff;
         c_excl_ff  <= c_excl_in;
         c_count_ff <= c_count_in;
         c_span_ff  <= c_span_in;
         c_idx_ff   <= b_idx_ff;
         c_side_ff  <= b_side_ff;
      end
      if (en[ST_D]) begin
         d_k_ff    <= c_k_ff;
         d_excl_ff <= c_excl_ff;
         d_span_ff <= c_span_ff;
         d_side_ff <= c_side_ff;
      end
      if (en[ST_E]) begin
         e_k_ff    <= d_k_ff;
         e_excl_ff <= d_excl_ff;
         e_span_ff <= d_span_ff;
         e_side_ff <= d_side_ff;
      end
      if (en[ST_F]) begin
         f_byte_ff <= f_byte_in;
         f_rank_ff <= f_rank_in;
         f_g_ff    <= f_g_in;
         f_os_ff   <= f_os_in;
         f_side_ff <= e_side_ff;
      end
      if (en[ST_G]) begin
         g_base_ff <= g_base_in;
         g_fold_ff <= g_fold_in;
         g_side_ff <= f_side_ff;
      end
      if (en[ST_H]) begin
         h_note_ff <= h_note_in;
         h_side_ff <= g_side_ff;
      end
   end

   assign rsp_ch.valid        = v_ff[ST_H];
   assign rsp_ch.note_channel = channel_ff;
   assign rsp_ch.note_number  = h_note_ff;
   assign rsp_ch.velocity     = h_side_ff.velocity;
   assign rsp_ch.duration_ms  = h_side_ff.duration_ms;
   assign rsp_ch.no_retrigger = suppress_ff;

endmodule

// File: rtl/core/cns_checker.sv
// Port-level checks for the chord note selector, bound to the top level.
// Depends on cns_pkg and chord_note_selector_top.
module cns_checker import cns_pkg::*; #(
   parameter int NOTE_RANGE = NOTE_RANGE_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [8:0] rsp_note_number,
   input logic [14:0]       rsp_velocity,
   input logic [23:0]       rsp_duration_ms
);

   localparam int NOTE_MIN = -32;
   localparam int NOTE_MAX = NOTE_RANGE - 12 + 31;

   // a stalled note beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_note_number)
         && $stable(rsp_velocity) && $stable(rsp_duration_ms))
      else $error("note beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("note beat present after reset");

   // with the output stage empty every stage can move, so the input never stalls
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   // folding keeps the note at or below the top octave before output transpose
   a_note_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_note_number >= NOTE_MIN) && (rsp_note_number <= NOTE_MAX))
      else $error("note number outside folded range");

endmodule

bind chord_note_selector_top cns_checker #(
   .NOTE_RANGE (NOTE_RANGE)
) u_cns_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_note_number (rsp_ch.note_number),
   .rsp_velocity    (rsp_ch.velocity),
   .rsp_duration_ms (rsp_ch.duration_ms)
);
